>>> design/ordered_list_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for ordered_list_engine_core
// Clocked checks, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define OLST_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_list_engine_core: assertion failed");

// next-cycle implication
`define OLST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_list_engine_core: assertion failed");

`endif

>>> design/olst_pkg.sv
// ---------------------------------------------------------------------------
// olst_pkg
// Field widths, action and status codes, and the cell control bundle.
// ---------------------------------------------------------------------------
package olst_pkg;

    localparam int ACT_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 7;

    localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PREPEND   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REM_LAST  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REM_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd6;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_REM  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic             rd_load;
        logic             rd_shift;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> design/olst_req_if.sv
// ---------------------------------------------------------------------------
// olst_req_if
// Request channel: valid/ready handshake with action, position and value.
// ---------------------------------------------------------------------------
interface olst_req_if;
    logic                             valid;
    logic                             ready;
    logic [olst_pkg::ACT_W-1:0]       action;
    logic [olst_pkg::POS_W-1:0]       position;
    logic signed [olst_pkg::VAL_W-1:0] value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

>>> design/olst_rsp_if.sv
// ---------------------------------------------------------------------------
// olst_rsp_if
// Response channel: valid/ready handshake with status, read value and count.
// ---------------------------------------------------------------------------
interface olst_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [olst_pkg::ST_W-1:0]         status;
    logic signed [olst_pkg::VAL_W-1:0] read_value;
    logic [olst_pkg::CNT_W-1:0]        count;

    modport source (output valid, output status, output read_value, output count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    output ready);
endinterface

>>> design/ordered_list_engine_core.sv
// ---------------------------------------------------------------------------
// ordered_list_engine_core
// Bounded positional list of signed 32-bit elements held in a row of cells.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one request item (action, position, value); o_rsp returns
//   one result item (status, read_value, count) for each request.
//   Append, prepend, insert and remove move every cell at once: each cell
//   takes its left or right neighbor or the new value, and the result is
//   registered and appears in the cycle after the request is accepted.
//   A read copies the row into the read lane, which shifts one cell toward
//   the head per cycle until the element reaches cell 0, then registers it.
//   One request is in flight at a time: throughput is one item per cycle
//   for edits while o_rsp.ready stays high; a read holds i_req.ready low.
//   A failed request (full list, bad index, empty list) changes nothing.
//   A new request is accepted while the previous result is taken in the
//   same cycle; while o_rsp is stalled the result register holds and
//   i_req.ready stays low.
//   Reset empties the list and drops any pending result; element storage
//   is not cleared, entries past the count are never read.
// ---------------------------------------------------------------------------
`include "ordered_list_engine_core_assert.svh"

module ordered_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olst_req_if.sink   i_req,
    olst_rsp_if.source o_rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                        r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [IW-1:0]               r_rd_cnt, n_rd_cnt;
    logic                        r_out_valid, n_out_valid;
    logic [olst_pkg::ST_W-1:0]   r_out_status, n_out_status;
    logic [olst_pkg::VAL_W-1:0]  r_out_rd, n_out_rd;
    logic [olst_pkg::CNT_W-1:0]  r_out_count, n_out_count;

    olst_pkg::t_cell_ctl         cell_ctl;
    logic [IW-1:0]               cell_idx;
    logic [olst_pkg::VAL_W-1:0]  cell_val [CAPACITY];
    logic [olst_pkg::VAL_W-1:0]  cell_rd  [CAPACITY];

    logic                        in_ready;
    logic                        acc;
    logic                        full;
    logic                        empty;
    logic [MW-1:0]               pos_m;
    logic [MW-1:0]               cnt_m;
    logic [olst_pkg::ST_W-1:0]   st;
    logic                        rd_go;
    logic                        grow_act;
    logic                        rd_last;

    assign in_ready    = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign acc         = i_req.valid && in_ready;
    assign i_req.ready = in_ready;
    assign full        = (r_count == CW'(CAPACITY));
    assign empty       = (r_count == '0);
    assign pos_m       = MW'(i_req.position);
    assign cnt_m       = MW'(r_count);
    assign grow_act    = (i_req.action == olst_pkg::ACT_APPEND) ||
                         (i_req.action == olst_pkg::ACT_PREPEND) ||
                         (i_req.action == olst_pkg::ACT_INSERT);
    assign rd_last     = (r_state == S_READ) && (r_rd_cnt == '0);

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_rd_cnt       = r_rd_cnt;
        n_out_valid    = r_out_valid && !o_rsp.ready;
        n_out_status   = r_out_status;
        n_out_rd       = r_out_rd;
        n_out_count    = r_out_count;
        cell_ctl.op       = olst_pkg::OP_HOLD;
        cell_ctl.rd_load  = 1'b0;
        cell_ctl.rd_shift = 1'b0;
        cell_ctl.value    = i_req.value;
        cell_idx       = '0;
        st             = olst_pkg::ST_OK;
        rd_go          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_req.action) inside
                        olst_pkg::ACT_APPEND, olst_pkg::ACT_PREPEND,
                        olst_pkg::ACT_INSERT: begin
                            if (full) begin
                                st = olst_pkg::ST_FULL;
                            end else if (i_req.action == olst_pkg::ACT_INSERT &&
                                         pos_m > cnt_m) begin
                                st = olst_pkg::ST_BAD;
                            end else begin
                                cell_ctl.op = olst_pkg::OP_INS;
                                if (i_req.action == olst_pkg::ACT_APPEND) begin
                                    cell_idx = IW'(r_count);
                                end else if (i_req.action == olst_pkg::ACT_INSERT) begin
                                    cell_idx = IW'(i_req.position);
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        olst_pkg::ACT_REMOVE: begin
                            if (pos_m >= cnt_m) begin
                                st = olst_pkg::ST_BAD;
                            end else begin
                                cell_ctl.op = olst_pkg::OP_REM;
                                cell_idx    = IW'(i_req.position);
                                n_count     = r_count - 1'b1;
                            end
                        end
                        olst_pkg::ACT_REM_LAST: begin
                            if (empty) begin
                                st = olst_pkg::ST_BAD;
                            end else begin
                                cell_ctl.op = olst_pkg::OP_REM;
                                cell_idx    = IW'(r_count - 1'b1);
                                n_count     = r_count - 1'b1;
                            end
                        end
                        olst_pkg::ACT_REM_FIRST: begin
                            if (empty) begin
                                st = olst_pkg::ST_BAD;
                            end else begin
                                cell_ctl.op = olst_pkg::OP_REM;
                                n_count     = r_count - 1'b1;
                            end
                        end
                        olst_pkg::ACT_READ: begin
                            if (pos_m >= cnt_m) begin
                                st = olst_pkg::ST_BAD;
                            end else begin
                                rd_go = 1'b1;
                            end
                        end
                        default: begin
                            st = olst_pkg::ST_BAD;
                        end
                    endcase

                    if (rd_go) begin
                        cell_ctl.rd_load = 1'b1;
                        n_rd_cnt         = IW'(i_req.position);
                        n_state          = S_READ;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = st;
                        n_out_rd     = '0;
                        n_out_count  = olst_pkg::CNT_W'(n_count);
                    end
                end
            end
            S_READ: begin
                if (r_rd_cnt == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = olst_pkg::ST_OK;
                    n_out_rd     = cell_rd[0];
                    n_out_count  = olst_pkg::CNT_W'(r_count);
                    n_state      = S_IDLE;
                end else begin
                    cell_ctl.rd_shift = 1'b1;
                    n_rd_cnt          = r_rd_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_rd     <= n_out_rd;
        r_out_count  <= n_out_count;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [olst_pkg::VAL_W-1:0] left, right, rd_right;

        if (g == 0) begin : g_head
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right    = '0;
            assign rd_right = '0;
        end else begin : g_mid_r
            assign right    = cell_val[g+1];
            assign rd_right = cell_rd[g+1];
        end

        olst_cell #(
            .IW       (IW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_idx      (cell_idx),
            .i_left     (left),
            .i_right    (right),
            .i_rd_right (rd_right),
            .o_val      (cell_val[g]),
            .o_rd       (cell_rd[g])
        );
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.count      = r_out_count;

    `OLST_ASSERT(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `OLST_ASSERT(a_busy_no_accept, i_clk, i_rst_n, r_state == S_READ, !i_req.ready)
    `OLST_ASSERT_NXT(a_full_holds, i_clk, i_rst_n, acc && full && grow_act, $stable(r_count))
    `OLST_ASSERT_NXT(a_read_done, i_clk, i_rst_n, rd_last, r_state == S_IDLE && r_out_valid)

endmodule

>>> design/olst_cell.sv
// ---------------------------------------------------------------------------
// olst_cell
// One list slot: holds, shifts toward the tail, shifts toward the head or
// loads a new element; carries a read lane that shifts toward the head.
// ---------------------------------------------------------------------------
module olst_cell #(
    parameter int IW       = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                       i_clk,
    input  olst_pkg::t_cell_ctl        i_ctl,
    input  logic [IW-1:0]              i_idx,
    input  logic [olst_pkg::VAL_W-1:0] i_left,
    input  logic [olst_pkg::VAL_W-1:0] i_right,
    input  logic [olst_pkg::VAL_W-1:0] i_rd_right,
    output logic [olst_pkg::VAL_W-1:0] o_val,
    output logic [olst_pkg::VAL_W-1:0] o_rd
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [olst_pkg::VAL_W-1:0] r_val, n_val;
    logic [olst_pkg::VAL_W-1:0] r_rd, n_rd;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            olst_pkg::OP_INS: begin
                if (MY_IDX > i_idx) begin
                    n_val = i_left;
                end else if (MY_IDX == i_idx) begin
                    n_val = i_ctl.value;
                end
            end
            olst_pkg::OP_REM: begin
                if (MY_IDX >= i_idx) begin
                    n_val = i_right;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_comb begin
        n_rd = r_rd;
        if (i_ctl.rd_load) begin
            n_rd = r_val;
        end else if (i_ctl.rd_shift) begin
            n_rd = i_rd_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_rd  <= n_rd;
    end

    assign o_val = r_val;
    assign o_rd  = r_rd;

endmodule

>>> tb/sv/tb_ordered_list_engine_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ordered_list_engine_core
// Self-checking bench for the bounded ordered list engine.
// A shadow list, kept as a SystemVerilog queue, predicts status, read value
// and count for every accepted request. Each returned item is compared with
// the oldest prediction. Directed cases cover the empty and full list, head
// and tail inserts and bad indexes. Random traffic then fills and drains the
// list under several sender idle and receiver stall mixes.
// ---------------------------------------------------------------------------
module tb_ordered_list_engine_core;

    localparam int LIST_CAPACITY  = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [olst_pkg::ACT_W-1:0] ACT_UNUSED = 3'd7;

    localparam logic signed [olst_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [olst_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [olst_pkg::ST_W-1:0]         status;
        logic signed [olst_pkg::VAL_W-1:0] read_value;
        logic [olst_pkg::CNT_W-1:0]        count;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    olst_req_if req_ch ();
    olst_rsp_if rsp_ch ();

    ordered_list_engine_core #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    logic signed [olst_pkg::VAL_W-1:0] shadow_list[$];
    t_list_result                      pending_results[$];
    int                      fail_count   = 0;
    int                      idle_cycles  = 0;
    int                      src_idle_pct = 0;
    int                      snk_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic t_list_result apply_list_request(
        input logic [olst_pkg::ACT_W-1:0]        act,
        input logic [olst_pkg::POS_W-1:0]        pos,
        input logic signed [olst_pkg::VAL_W-1:0] val
    );
        t_list_result res;
        int           n;
        n              = shadow_list.size();
        res.status     = olst_pkg::ST_OK;
        res.read_value = '0;
        case (act)
            olst_pkg::ACT_APPEND, olst_pkg::ACT_PREPEND, olst_pkg::ACT_INSERT: begin
                if (n >= LIST_CAPACITY) begin
                    res.status = olst_pkg::ST_FULL;
                end else if (act == olst_pkg::ACT_APPEND) begin
                    shadow_list.push_back(val);
                end else if (act == olst_pkg::ACT_PREPEND) begin
                    shadow_list.push_front(val);
                end else if (pos > n) begin
                    res.status = olst_pkg::ST_BAD;
                end else begin
                    shadow_list.insert(pos, val);
                end
            end
            olst_pkg::ACT_REMOVE: begin
                if (pos >= n) res.status = olst_pkg::ST_BAD;
                else shadow_list.delete(pos);
            end
            olst_pkg::ACT_REM_LAST: begin
                if (n == 0) res.status = olst_pkg::ST_BAD;
                else void'(shadow_list.pop_back());
            end
            olst_pkg::ACT_REM_FIRST: begin
                if (n == 0) res.status = olst_pkg::ST_BAD;
                else void'(shadow_list.pop_front());
            end
            olst_pkg::ACT_READ: begin
                if (pos >= n) res.status = olst_pkg::ST_BAD;
                else res.read_value = shadow_list[pos];
            end
            default: res.status = olst_pkg::ST_BAD;
        endcase
        res.count = olst_pkg::CNT_W'(shadow_list.size());
        return res;
    endfunction

    // request/response monitor, result check and watchdog
    always @(posedge i_clk) begin
        t_list_result want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                moved = 1'b1;
                pending_results.push_back(
                    apply_list_request(req_ch.action, req_ch.position, req_ch.value));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: status %0d read_value %0d count %0d",
                           rsp_ch.status, rsp_ch.read_value, rsp_ch.count);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, rsp_ch.read_value);
                        fail_count++;
                    end
                    if (rsp_ch.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                        fail_count++;
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(
        input logic [olst_pkg::ACT_W-1:0]        act,
        input logic [olst_pkg::POS_W-1:0]        pos,
        input logic signed [olst_pkg::VAL_W-1:0] val
    );
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic signed [olst_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_edge_cases();
        send_request(olst_pkg::ACT_REM_LAST, 0, 0);
        send_request(olst_pkg::ACT_REM_FIRST, 0, 0);
        send_request(olst_pkg::ACT_REMOVE, 0, 0);
        send_request(olst_pkg::ACT_READ, 0, 0);
        send_request(olst_pkg::ACT_INSERT, 1, 5);
        send_request(olst_pkg::ACT_PREPEND, 0, VAL_MAX);     // into empty list
        send_request(olst_pkg::ACT_INSERT, 0, VAL_MIN);      // at head
        send_request(olst_pkg::ACT_INSERT, 2, -1);           // at tail
        send_request(olst_pkg::ACT_APPEND, 127, 0);
        send_request(olst_pkg::ACT_INSERT, 5, 7);            // past count
        send_request(olst_pkg::ACT_READ, 0, 0);
        send_request(olst_pkg::ACT_READ, 1, 0);
        send_request(olst_pkg::ACT_READ, 2, 0);
        send_request(olst_pkg::ACT_READ, 3, 0);
        send_request(olst_pkg::ACT_READ, 4, 0);
        send_request(olst_pkg::ACT_READ, 64, 0);
        send_request(olst_pkg::ACT_READ, 127, 0);
        send_request(ACT_UNUSED, 0, VAL_MAX);
        send_request(olst_pkg::ACT_REMOVE, 1, 0);
        send_request(olst_pkg::ACT_REMOVE, 3, 0);
        send_request(olst_pkg::ACT_REM_LAST, 0, 0);
        send_request(olst_pkg::ACT_REM_FIRST, 0, 0);
        send_request(olst_pkg::ACT_REM_FIRST, 0, 0);
        send_request(olst_pkg::ACT_REM_LAST, 0, 0);
    endtask

    // list is empty on entry, so this many appends fill it
    task automatic test_full_list();
        repeat (LIST_CAPACITY)
            send_request(olst_pkg::ACT_APPEND, olst_pkg::POS_W'($urandom_range(127)),
                         pick_value());
        send_request(olst_pkg::ACT_APPEND, 0, 1);
        send_request(olst_pkg::ACT_PREPEND, 0, 2);
        send_request(olst_pkg::ACT_INSERT, 65, 3);           // full wins over bad index
        send_request(olst_pkg::ACT_INSERT, 0, 4);
        send_request(olst_pkg::ACT_READ, 63, 0);
        send_request(olst_pkg::ACT_READ, 64, 0);
        send_request(olst_pkg::ACT_REMOVE, 64, 0);
    endtask

    task automatic send_random_block(input int num_items, input int grow_pct);
        int                               r;
        int                               cnt;
        logic [olst_pkg::ACT_W-1:0]       act;
        logic [olst_pkg::POS_W-1:0]       pos;
        for (int i = 0; i < num_items; i++) begin
            r   = $urandom_range(99);
            cnt = shadow_list.size();
            pos = olst_pkg::POS_W'($urandom_range(127));
            if (r < grow_pct) begin
                case ($urandom_range(2))
                    0:       act = olst_pkg::ACT_APPEND;
                    1:       act = olst_pkg::ACT_PREPEND;
                    default: begin
                        act = olst_pkg::ACT_INSERT;
                        pos = olst_pkg::POS_W'($urandom_range(cnt));
                    end
                endcase
            end else if ($urandom_range(9) < 6) begin
                case ($urandom_range(2))
                    0:       act = olst_pkg::ACT_REM_LAST;
                    1:       act = olst_pkg::ACT_REM_FIRST;
                    default: begin
                        act = olst_pkg::ACT_REMOVE;
                        if (cnt > 0) pos = olst_pkg::POS_W'($urandom_range(cnt - 1));
                    end
                endcase
            end else if ($urandom_range(3) != 0) begin
                act = olst_pkg::ACT_READ;
                if (cnt > 0) pos = olst_pkg::POS_W'($urandom_range(cnt - 1));
            end else begin
                act = olst_pkg::ACT_W'($urandom_range(7));
            end
            send_request(act, pos, pick_value());
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        send_random_block(90, 10);     // drain
        send_random_block(90, 88);     // fill toward full
        send_random_block(45, 45);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = olst_pkg::ACT_APPEND;
        req_ch.position = '0;
        req_ch.value    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_full_list();
        test_random_traffic(0, 0);
        test_random_traffic(45, 0);
        test_random_traffic(0, 45);
        test_random_traffic(15, 15);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LIST_CAPACITY + 4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
